// ===== hw/rtl/tchfe_pkg.sv =====
package tchfe_pkg;

  // Fields of one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_last;
  } in_t;

  // Fields of one result request
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  msg_type;
    logic [1:0]  error_code;
    logic        message_end;
  } out_t;

  // Result kinds
  localparam logic [3:0] KIND_HDR     = 4'd0;
  localparam logic [3:0] KIND_VER     = 4'd1;
  localparam logic [3:0] KIND_TS      = 4'd2;
  localparam logic [3:0] KIND_RAND    = 4'd3;
  localparam logic [3:0] KIND_SIDLEN  = 4'd4;
  localparam logic [3:0] KIND_SID     = 4'd5;
  localparam logic [3:0] KIND_SUITE   = 4'd6;
  localparam logic [3:0] KIND_COMP    = 4'd7;
  localparam logic [3:0] KIND_EXT     = 4'd8;
  localparam logic [3:0] KIND_ERR     = 4'd9;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SHORT    = 2'd1;
  localparam logic [1:0] ERR_SID      = 2'd2;
  localparam logic [1:0] ERR_SUITE    = 2'd3;

  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [23:0] MIN_HELLO       = 24'd35;
  localparam logic [5:0]  RAND_BYTES      = 6'd28;

  // Result queue geometry
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;

  // Parser phase, one-hot
  typedef enum logic [14:0] {
    PH_HDR      = 15'b000000000000001,
    PH_VER      = 15'b000000000000010,
    PH_TS       = 15'b000000000000100,
    PH_RAND     = 15'b000000000001000,
    PH_SIDLEN   = 15'b000000000010000,
    PH_SID      = 15'b000000000100000,
    PH_SUITELEN = 15'b000000001000000,
    PH_SUITES   = 15'b000000010000000,
    PH_COMPLEN  = 15'b000000100000000,
    PH_COMP     = 15'b000001000000000,
    PH_EXTSLEN  = 15'b000010000000000,
    PH_EXTHDR   = 15'b000100000000000,
    PH_EXTBODY  = 15'b001000000000000,
    PH_SKIPMSG  = 15'b010000000000000,
    PH_DRAIN    = 15'b100000000000000
  } phase_t;

  // Parser state
  typedef struct packed {
    phase_t      phase;
    logic [5:0]  fbc;
    logic [23:0] msg_rem;
    logic [15:0] list_rem;
    logic [31:0] acc;
    logic [7:0]  cur_type;
    logic [15:0] skip_rem;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:    PH_HDR,
    fbc:      6'd0,
    msg_rem:  24'd0,
    list_rem: 16'd0,
    acc:      32'd0,
    cur_type: 8'd0,
    skip_rem: 16'd0
  };

  // Up to two results made by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } step_res_t;

  function automatic out_t mk_res(input logic [3:0] kind, input logic [31:0] value,
                                  input logic [7:0] mtype, input logic [1:0] err,
                                  input logic mend);
    out_t o;
    o.kind        = kind;
    o.value       = value;
    o.msg_type    = mtype;
    o.error_code  = err;
    o.message_end = mend;
    return o;
  endfunction

endpackage

// ===== hw/rtl/tchfe_step.sv =====
module tchfe_step (
  input  tchfe_pkg::state_t    st,
  input  tchfe_pkg::in_t       req,
  output tchfe_pkg::state_t    st_nxt,
  output tchfe_pkg::step_res_t res
);

  // Next parser state and results for one byte
  always_comb begin
    logic [31:0] acc_sh;
    logic [5:0]  fbc_inc;
    logic [23:0] rem;
    logic [15:0] lst_dec;
    logic [15:0] skip_dec;
    logic [1:0]  err;
    tchfe_pkg::out_t eres;

    acc_sh   = {st.acc[23:0], req.data_byte};
    fbc_inc  = st.fbc + 6'd1;
    rem      = st.msg_rem - 24'd1;
    lst_dec  = st.list_rem - 16'd1;
    skip_dec = st.skip_rem - 16'd1;
    err      = tchfe_pkg::ERR_NONE;
    st_nxt   = st;
    res      = '0;

    if (st.phase == tchfe_pkg::PH_HDR) begin
      st_nxt.acc = acc_sh;
      st_nxt.fbc = fbc_inc;
      if (fbc_inc >= 6'd4) begin
        st_nxt.cur_type = acc_sh[31:24];
        st_nxt.msg_rem  = acc_sh[23:0];
        st_nxt.fbc      = 6'd0;
        st_nxt.list_rem = 16'd0;
        st_nxt.acc      = 32'd0;
        st_nxt.skip_rem = 16'd0;
        res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_HDR, {8'd0, acc_sh[23:0]},
                                   acc_sh[31:24], tchfe_pkg::ERR_NONE, 1'b0);
        res.cnt = 2'd1;
        if (acc_sh[31:24] == tchfe_pkg::HS_CLIENT_HELLO &&
            acc_sh[23:0] < tchfe_pkg::MIN_HELLO) begin
          // short hello: header, then error
          res.r1 = tchfe_pkg::mk_res(tchfe_pkg::KIND_ERR, 32'd0, acc_sh[31:24],
                                     tchfe_pkg::ERR_SHORT, 1'b1);
          res.cnt = 2'd2;
          st_nxt.phase = tchfe_pkg::PH_DRAIN;
        end else if (acc_sh[23:0] == 24'd0) begin
          res.r0.message_end = 1'b1;
        end else if (acc_sh[31:24] == tchfe_pkg::HS_CLIENT_HELLO) begin
          st_nxt.phase = tchfe_pkg::PH_VER;
        end else begin
          st_nxt.phase = tchfe_pkg::PH_SKIPMSG;
        end
      end
    end else if (st.phase != tchfe_pkg::PH_DRAIN) begin
      st_nxt.msg_rem = rem;
      // body byte, by phase
      unique case (st.phase)
        tchfe_pkg::PH_VER: begin
          st_nxt.acc = acc_sh;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd2) begin
            res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_VER, {16'd0, acc_sh[15:0]},
                                       st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
            res.cnt = 2'd1;
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
            st_nxt.phase = tchfe_pkg::PH_TS;
          end
        end
        tchfe_pkg::PH_TS: begin
          st_nxt.acc = acc_sh;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd4) begin
            res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_TS, acc_sh, st.cur_type,
                                       tchfe_pkg::ERR_NONE, 1'b0);
            res.cnt = 2'd1;
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
            st_nxt.phase = tchfe_pkg::PH_RAND;
          end
        end
        tchfe_pkg::PH_RAND: begin
          res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_RAND, {24'd0, req.data_byte},
                                     st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
          res.cnt = 2'd1;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= tchfe_pkg::RAND_BYTES) begin
            st_nxt.fbc = 6'd0;
            st_nxt.phase = tchfe_pkg::PH_SIDLEN;
          end
        end
        tchfe_pkg::PH_SIDLEN: begin
          res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_SIDLEN, {24'd0, req.data_byte},
                                     st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
          res.cnt = 2'd1;
          if ({16'd0, req.data_byte} > rem) begin
            err = tchfe_pkg::ERR_SID;
          end else begin
            st_nxt.list_rem = {8'd0, req.data_byte};
            st_nxt.phase = (req.data_byte != 8'd0) ? tchfe_pkg::PH_SID
                                                   : tchfe_pkg::PH_SUITELEN;
          end
        end
        tchfe_pkg::PH_SID: begin
          res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_SID, {24'd0, req.data_byte},
                                     st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
          res.cnt = 2'd1;
          st_nxt.list_rem = lst_dec;
          if (lst_dec == 16'd0) st_nxt.phase = tchfe_pkg::PH_SUITELEN;
        end
        tchfe_pkg::PH_SUITELEN: begin
          st_nxt.acc = acc_sh;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd2) begin
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
            if ({8'd0, acc_sh[15:0]} > rem) begin
              err = tchfe_pkg::ERR_SUITE;
            end else begin
              st_nxt.list_rem = acc_sh[15:0];
              st_nxt.phase = (acc_sh[15:0] != 16'd0) ? tchfe_pkg::PH_SUITES
                                                     : tchfe_pkg::PH_COMPLEN;
            end
          end
        end
        tchfe_pkg::PH_SUITES: begin
          st_nxt.acc = acc_sh;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd2) begin
            res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_SUITE, {16'd0, acc_sh[15:0]},
                                       st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
            res.cnt = 2'd1;
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
          end
          st_nxt.list_rem = lst_dec;
          // odd trailing byte is dropped here
          if (lst_dec == 16'd0) begin
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
            st_nxt.phase = tchfe_pkg::PH_COMPLEN;
          end
        end
        tchfe_pkg::PH_COMPLEN: begin
          st_nxt.list_rem = {8'd0, req.data_byte};
          st_nxt.phase = (req.data_byte != 8'd0) ? tchfe_pkg::PH_COMP
                                                 : tchfe_pkg::PH_EXTSLEN;
        end
        tchfe_pkg::PH_COMP: begin
          res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_COMP, {24'd0, req.data_byte},
                                     st.cur_type, tchfe_pkg::ERR_NONE, 1'b0);
          res.cnt = 2'd1;
          st_nxt.list_rem = lst_dec;
          if (lst_dec == 16'd0) st_nxt.phase = tchfe_pkg::PH_EXTSLEN;
        end
        tchfe_pkg::PH_EXTSLEN: begin
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd2) begin
            st_nxt.fbc = 6'd0;
            st_nxt.phase = tchfe_pkg::PH_EXTHDR;
          end
        end
        tchfe_pkg::PH_EXTHDR: begin
          st_nxt.acc = acc_sh;
          st_nxt.fbc = fbc_inc;
          if (fbc_inc >= 6'd4) begin
            res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_EXT, acc_sh, st.cur_type,
                                       tchfe_pkg::ERR_NONE, 1'b0);
            res.cnt = 2'd1;
            st_nxt.skip_rem = acc_sh[15:0];
            st_nxt.fbc = 6'd0;
            st_nxt.acc = 32'd0;
            st_nxt.phase = (acc_sh[15:0] != 16'd0) ? tchfe_pkg::PH_EXTBODY
                                                   : tchfe_pkg::PH_EXTHDR;
          end
        end
        tchfe_pkg::PH_EXTBODY: begin
          st_nxt.skip_rem = skip_dec;
          if (skip_dec == 16'd0) st_nxt.phase = tchfe_pkg::PH_EXTHDR;
        end
        default: begin
          // skipped message body: nothing but the length count
        end
      endcase

      // message ended before the session id or suite length was complete
      if (err == tchfe_pkg::ERR_NONE && rem == 24'd0 &&
          (st_nxt.phase == tchfe_pkg::PH_SID || st_nxt.phase == tchfe_pkg::PH_SUITELEN))
        err = tchfe_pkg::ERR_SUITE;

      eres = tchfe_pkg::mk_res(tchfe_pkg::KIND_ERR, 32'd0, st.cur_type, err, 1'b1);
      if (err != tchfe_pkg::ERR_NONE) begin
        if (res.cnt == 2'd0) begin
          res.r0 = eres;
          res.cnt = 2'd1;
        end else begin
          res.r1 = eres;
          res.cnt = 2'd2;
        end
        st_nxt.phase    = tchfe_pkg::PH_DRAIN;
        st_nxt.fbc      = 6'd0;
        st_nxt.list_rem = 16'd0;
        st_nxt.acc      = 32'd0;
        st_nxt.skip_rem = 16'd0;
      end else if (rem == 24'd0) begin
        // close the message, with an end marker if the byte gave nothing
        if (res.cnt != 2'd0) begin
          res.r0.message_end = 1'b1;
        end else begin
          res.r0 = tchfe_pkg::mk_res(tchfe_pkg::KIND_HDR, 32'd0, st.cur_type,
                                     tchfe_pkg::ERR_NONE, 1'b1);
          res.cnt = 2'd1;
        end
        st_nxt.phase    = tchfe_pkg::PH_HDR;
        st_nxt.fbc      = 6'd0;
        st_nxt.list_rem = 16'd0;
        st_nxt.acc      = 32'd0;
        st_nxt.skip_rem = 16'd0;
      end
    end

    // end of record restarts the parser
    if (req.record_last) st_nxt = tchfe_pkg::ST_RESET;
  end

endmodule

// ===== hw/rtl/tchfe_rq.sv =====
module tchfe_rq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tchfe_pkg::step_res_t res,
  output logic                 no_room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tchfe_pkg::out_t      out_data
);

  tchfe_pkg::out_t            mem_r [tchfe_pkg::RQ_DEPTH];
  logic [tchfe_pkg::RQ_AW-1:0] wr_r, wr_nxt;
  logic [tchfe_pkg::RQ_AW-1:0] rd_r, rd_nxt;
  logic [tchfe_pkg::RQ_AW:0]   count_r, count_nxt;
  logic [1:0]                  n_push;
  logic                        pop;

  // Pointer and level bookkeeping
  always_comb begin
    n_push    = push ? res.cnt : 2'd0;
    pop       = out_valid && !out_stall;
    wr_nxt    = wr_r + n_push[tchfe_pkg::RQ_AW-1:0];
    rd_nxt    = rd_r + {{(tchfe_pkg::RQ_AW-1){1'b0}}, pop};
    count_nxt = count_r + {1'b0, n_push} - {{tchfe_pkg::RQ_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Result storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r] <= res.r0;
    if (n_push == 2'd2) mem_r[wr_r + {{(tchfe_pkg::RQ_AW-1){1'b0}}, 1'b1}] <= res.r1;
  end

  // Room for two more is needed before a byte is taken
  assign no_room   = count_r > 3'd2;
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_r];

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue level above depth");

  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r == rd_r + count_r[tchfe_pkg::RQ_AW-1:0])
    else $error("queue pointers disagree with level");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r <= 3'd2)
    else $error("push into queue without room for two");

endmodule

// ===== hw/rtl/tls_client_hello_field_extractor_unit.sv =====
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | tchfe_pkg::in_t  (data_byte, record_last)
// out_    | output    | out_valid / out_stall | tchfe_pkg::out_t (kind, value, msg_type,
//         |           |                       |   error_code, message_end)
// One byte per cycle while in_stall is low: the parser state updates in the cycle the
// byte is taken, and its zero, one or two results are written into a four-entry result
// queue at that same edge and read out one per cycle while out_stall is low.
// in_stall rises while more than two results wait in the queue; a stalled output
// throttles the input once three results are queued, a free-running one never does.
// Synchronous active-low reset returns the parser to the header phase, empties the queue.
module tls_client_hello_field_extractor_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tchfe_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tchfe_pkg::out_t out_data
);

  tchfe_pkg::state_t    state_r, state_nxt;
  tchfe_pkg::step_res_t step_res;
  logic                 in_acc;
  logic                 no_room;

  assign in_stall = no_room;
  assign in_acc   = in_valid && !no_room;

  // Per-byte parser logic
  tchfe_step u_step (
    .st     (state_r),
    .req    (in_data),
    .st_nxt (state_nxt),
    .res    (step_res)
  );

  // Parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tchfe_pkg::ST_RESET;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result queue
  tchfe_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .res       (step_res),
    .no_room   (no_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.record_last |=> state_r.phase == tchfe_pkg::PH_HDR &&
                                      state_r.fbc == 6'd0)
    else $error("parser not back at header after record end");

  a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == tchfe_pkg::PH_DRAIN |-> step_res.cnt == 2'd0)
    else $error("result produced while draining after an error");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && no_room |=> state_r == $past(state_r))
    else $error("parser state moved on a stalled byte");

endmodule
